@@ sv/text_console_char_writer_macros.svh @@
// assertion macros for the text console writer
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TCCW_ASSERT_NOW(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TCCW_ASSERT_NOW(lbl, prop, msg)

`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/tccw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tccw_pkg;

    localparam int COLOR_W = 16;
    localparam int CHAR_W  = 8;
    localparam int CELL_W  = COLOR_W + CHAR_W;

    localparam logic [CHAR_W-1:0]  CH_CR       = 8'h0d;
    localparam logic [CHAR_W-1:0]  CH_LF       = 8'h0a;
    localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0]  CH_FIRST    = 8'h20;
    localparam logic [CHAR_W-1:0]  CH_LAST     = 8'h7e;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 16'h00f0;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  char_code;
        logic [11:0] cell_address;
    } in_word_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [5:0]  cursor_row;
        logic        scrolled;
        logic [23:0] cell_data;
    } out_word_t;

endpackage

`default_nettype wire

@@ sv/text_console_char_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_char_writer_macros.svh"

// Text console writer: takes one command word at a time, either a character byte to put
// at the cursor or a read of one stored cell, and returns one result word for each. The
// screen lives in a single-port-write, registered-read cell memory of COLUMNS*ROWS
// entries arranged as a ring of rows, so a scroll moves a top-row pointer instead of
// copying the screen. A put (CR, LF, printable or ignored byte) is handled in the idle
// state; a read waits in a read state for the registered memory read data; a put that
// scrolls then blanks all COLUMNS cells of the recycled row (80 with the default size)
// before the next word is taken. After reset the block writes blank cells to all
// COLUMNS*ROWS entries (4000 by default) before it takes its first word; color writes
// are taken at any time and apply to cells written afterwards and to rows blanked by
// later scrolls; a row being blanked keeps the color in force when its scroll was taken.
module text_console_char_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 50
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire tccw_pkg::in_word_t  in_word,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output tccw_pkg::out_word_t      out_word,
    input  wire logic                color_we,
    input  wire logic [15:0]         color_wdata
);

    import tccw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int SW    = ((AW > 12) ? AW : 12) + 1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_BLANK = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [COLOR_W-1:0]  color_reg;
    logic [COLOR_W-1:0]  blank_color_reg, blank_color_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [AW-1:0]       cur_base_reg, cur_base_next;
    logic [AW-1:0]       top_base_reg, top_base_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                in_range_reg, in_range_next;
    logic                out_valid_reg, out_valid_next;
    out_word_t           out_word_reg, out_word_next;
    logic [CELL_W-1:0]   rd_data_reg;

    logic [CELL_W-1:0]   cell_mem [CELLS];

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    logic                out_free;
    logic                in_acc;
    logic                is_read, is_cr, is_lf, is_print;
    logic [CW:0]         col_inc;
    logic                wrap, adv_row, scroll;
    logic [AW:0]         cur_base_inc, top_base_inc;
    logic [AW-1:0]       cur_base_wrap, top_base_wrap;
    logic [SW-1:0]       addr_ext, phys_sum, phys_addr;
    logic [31:0]         col_out_ext, row_out_ext, col_cur_ext, row_cur_ext;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == S_IDLE) && out_free);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign is_read  = (in_word.command == CMD_READ);
    assign is_cr    = (in_word.char_code == CH_CR);
    assign is_lf    = (in_word.char_code == CH_LF);
    assign is_print = (in_word.char_code >= CH_FIRST) && (in_word.char_code <= CH_LAST);

    assign col_inc = {1'b0, col_reg} + (CW + 1)'(1);
    assign wrap    = is_print && (col_inc == (CW + 1)'(COLUMNS));
    assign adv_row = is_lf || wrap;
    assign scroll  = adv_row && (row_reg == RW'(ROWS - 1));

    // ring of rows: step a row base forward by one row
    assign cur_base_inc  = {1'b0, cur_base_reg} + (AW + 1)'(COLUMNS);
    assign cur_base_wrap = (cur_base_inc >= (AW + 1)'(CELLS))
                         ? AW'(cur_base_inc - (AW + 1)'(CELLS)) : cur_base_inc[AW-1:0];
    assign top_base_inc  = {1'b0, top_base_reg} + (AW + 1)'(COLUMNS);
    assign top_base_wrap = (top_base_inc >= (AW + 1)'(CELLS))
                         ? AW'(top_base_inc - (AW + 1)'(CELLS)) : top_base_inc[AW-1:0];

    // read address, logical to physical
    assign addr_ext  = SW'(in_word.cell_address);
    assign phys_sum  = addr_ext + SW'(top_base_reg);
    assign phys_addr = (phys_sum >= SW'(CELLS)) ? (phys_sum - SW'(CELLS)) : phys_sum;

    assign col_out_ext = 32'(col_next);
    assign row_out_ext = 32'(row_next);
    assign col_cur_ext = 32'(col_reg);
    assign row_cur_ext = 32'(row_reg);

    always_comb
    begin
        state_next       = state_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        cur_base_next    = cur_base_reg;
        top_base_next    = top_base_reg;
        addr_next        = addr_reg;
        cnt_next         = cnt_reg;
        blank_color_next = blank_color_reg;
        in_range_next    = in_range_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_word_next    = out_word_reg;
        mem_we           = 1'b0;
        mem_waddr        = addr_reg;
        mem_wdata        = {color_reg, CH_SPACE};
        mem_re           = 1'b0;
        mem_raddr        = phys_addr[AW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_COLOR, CH_SPACE};
                addr_next = addr_reg + AW'(1);
                if (addr_reg == AW'(CELLS - 1))
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (is_read)
                    begin
                        in_range_next = (addr_ext < SW'(CELLS));
                        mem_re        = (addr_ext < SW'(CELLS));
                        state_next    = S_READ;
                    end
                    else
                    begin
                        if (is_cr)
                        begin
                            col_next = '0;
                        end
                        if (is_print)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_base_reg + AW'(col_reg);
                            mem_wdata = {color_reg, in_word.char_code};
                            col_next  = wrap ? '0 : col_inc[CW-1:0];
                        end
                        if (adv_row)
                        begin
                            cur_base_next = cur_base_wrap;
                            if (scroll)
                            begin
                                top_base_next    = top_base_wrap;
                                addr_next        = cur_base_wrap;
                                cnt_next         = '0;
                                blank_color_next = color_reg;
                                state_next       = S_BLANK;
                            end
                            else
                            begin
                                row_next = row_reg + RW'(1);
                            end
                        end
                        out_valid_next           = 1'b1;
                        out_word_next.cursor_col = col_out_ext[6:0];
                        out_word_next.cursor_row = row_out_ext[5:0];
                        out_word_next.scrolled   = scroll;
                        out_word_next.cell_data  = '0;
                    end
                end
            end
            S_READ:
            begin
                out_valid_next           = 1'b1;
                out_word_next.cursor_col = col_cur_ext[6:0];
                out_word_next.cursor_row = row_cur_ext[5:0];
                out_word_next.scrolled   = 1'b0;
                out_word_next.cell_data  = in_range_reg ? rd_data_reg : '0;
                state_next               = S_IDLE;
            end
            S_BLANK:
            begin
                mem_we    = 1'b1;
                mem_wdata = {blank_color_reg, CH_SPACE};
                addr_next = addr_reg + AW'(1);
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(COLUMNS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            color_reg       <= RESET_COLOR;
            blank_color_reg <= RESET_COLOR;
            col_reg         <= '0;
            row_reg         <= '0;
            cur_base_reg    <= '0;
            top_base_reg    <= '0;
            addr_reg        <= '0;
            cnt_reg         <= '0;
            in_range_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            blank_color_reg <= blank_color_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            cur_base_reg    <= cur_base_next;
            top_base_reg    <= top_base_next;
            addr_reg        <= addr_next;
            cnt_reg         <= cnt_next;
            in_range_reg    <= in_range_next;
            out_valid_reg   <= out_valid_next;
            if (color_we)
            begin
                color_reg <= color_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    // cell memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= cell_mem[mem_raddr];
        end
    end

    `TCCW_ASSERT_NOW(a_no_accept_busy, (state_reg == S_IDLE) || in_stall, "word taken while busy")
    `TCCW_ASSERT_NOW(a_cursor_range, (32'(col_reg) < COLUMNS) && (32'(row_reg) < ROWS), "cursor out of range")
    `TCCW_ASSERT_NEXT(a_read_wait, in_acc && is_read, state_reg == S_READ, "read not waiting for data")
    `TCCW_ASSERT_NEXT(a_scroll_blank, in_acc && !is_read && scroll, state_reg == S_BLANK, "scroll without blanking")

endmodule

`default_nettype wire

@@ test/text_console_char_writer_tb.sv @@
`timescale 1ns / 1ps

module text_console_char_writer_tb;
    import tccw_pkg::*;

    localparam int COLS = 80;
    localparam int ROWS = 50;
    localparam int CELLS = COLS * ROWS;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = COLS + 20;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_word_t in_word;
    logic out_valid;
    logic out_stall;
    out_word_t out_word;
    logic color_we;
    logic [15:0] color_wdata;

    // screen model and cursor
    logic [23:0] screen_model [CELLS];
    logic [15:0] color_model;
    int col_pos;
    int row_pos;

    out_word_t expected_words [$];
    out_word_t exp_w;
    int fail_count = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;

    text_console_char_writer #(
        .COLUMNS (COLS),
        .ROWS    (ROWS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_word     (in_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_word    (out_word),
        .color_we    (color_we),
        .color_wdata (color_wdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // cursor moves down one row, scrolling at the bottom
    function automatic logic advance_row();
        int i;
        row_pos++;
        if (row_pos < ROWS)
        begin
            return 1'b0;
        end
        row_pos = ROWS - 1;
        for (i = 0; i < CELLS - COLS; i++)
        begin
            screen_model[12'(i)] = screen_model[12'(i + COLS)];
        end
        for (i = CELLS - COLS; i < CELLS; i++)
        begin
            screen_model[12'(i)] = {color_model, CH_SPACE};
        end
        return 1'b1;
    endfunction

    function automatic out_word_t console_step(input in_word_t w);
        out_word_t r;
        r = '0;
        if (w.command == CMD_READ)
        begin
            if (w.cell_address < CELLS)
            begin
                r.cell_data = screen_model[w.cell_address];
            end
        end
        else if (w.char_code == CH_CR)
        begin
            col_pos = 0;
        end
        else if (w.char_code == CH_LF)
        begin
            r.scrolled = advance_row();
        end
        else if (w.char_code >= CH_FIRST && w.char_code <= CH_LAST)
        begin
            screen_model[12'(row_pos * COLS + col_pos)] = {color_model, w.char_code};
            col_pos++;
            if (col_pos >= COLS)
            begin
                col_pos = 0;
                r.scrolled = advance_row();
            end
        end
        r.cursor_col = col_pos[6:0];
        r.cursor_row = row_pos[5:0];
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input in_word_t w);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_word <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        expected_words.push_back(console_step(w));
        @(negedge clk);
    endtask

    task automatic put_char(input logic [7:0] code);
        in_word_t w;
        w.command = CMD_PUT;
        w.char_code = code;
        w.cell_address = 12'($urandom_range(0, 4095));
        send_word(w);
    endtask

    task automatic read_cell(input int addr);
        in_word_t w;
        w.command = CMD_READ;
        w.char_code = 8'($urandom_range(0, 255));
        w.cell_address = addr[11:0];
        send_word(w);
    endtask

    // only while idle, with time for a pending row blank to finish
    task automatic set_color(input logic [15:0] value);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        color_we <= 1'b1;
        color_wdata <= value;
        @(negedge clk);
        color_we <= 1'b0;
        color_model = value;
    endtask

    task automatic test_reset_state();
        read_cell(0);
        read_cell(1234);
        read_cell(CELLS - 1);
        read_cell(CELLS);
        read_cell(4095);
    endtask

    task automatic test_char_codes();
        put_char(8'h00);
        put_char(8'hff);
        put_char(8'h7f);
        put_char(8'h1f);
        put_char(CH_FIRST);
        put_char(CH_LAST);
        put_char(8'h41);
        put_char(CH_CR);
        put_char(CH_LF);
        put_char(8'h42);
        read_cell(0);
        read_cell(1);
        read_cell(2);
        read_cell(3);
        read_cell(COLS);
    endtask

    task automatic test_color();
        set_color(16'hffff);
        put_char(8'h5a);
        set_color(16'h0000);
        put_char(8'h61);
        read_cell(COLS + 1);
        read_cell(COLS + 2);
        read_cell(0);
    endtask

    task automatic test_wrap_and_scroll();
        int k;
        set_color(16'($urandom_range(0, 65535)));
        put_char(CH_CR);
        while (row_pos < ROWS - 1)
        begin
            put_char(CH_LF);
        end
        for (k = 0; k < COLS; k++)
        begin
            put_char(8'($urandom_range(8'h20, 8'h7e)));
        end
        put_char(CH_LF);
        read_cell(0);
        read_cell((ROWS - 3) * COLS + 7);
        read_cell(CELLS - COLS);
        read_cell(CELLS - 1);
    endtask

    task automatic test_random();
        int phase;
        int k;
        int sel;
        in_word_t w;
        for (phase = 0; phase < 4; phase++)
        begin
            if (phase > 0)
            begin
                set_color(16'($urandom_range(0, 65535)));
            end
            if (phase == 3)
            begin
                calm = 1'b1;
            end
            for (k = 0; k < 60; k++)
            begin
                sel = $urandom_range(0, 99);
                w.command = CMD_PUT;
                w.char_code = 8'($urandom_range(8'h20, 8'h7e));
                w.cell_address = 12'($urandom_range(0, 4095));
                if (sel < 10)
                begin
                    w.char_code = CH_LF;
                end
                else if (sel < 17)
                begin
                    w.char_code = CH_CR;
                end
                else if (sel < 25)
                begin
                    w.char_code = 8'($urandom_range(0, 255));
                end
                else if (sel < 35)
                begin
                    w.command = CMD_READ;
                    w.char_code = 8'($urandom_range(0, 255));
                    w.cell_address = 12'(row_pos * COLS + $urandom_range(0, COLS - 1));
                end
                else if (sel < 45)
                begin
                    w.command = CMD_READ;
                    w.char_code = 8'($urandom_range(0, 255));
                end
                send_word(w);
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result word with no expectation waiting");
                fail_count++;
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (out_word.cursor_col !== exp_w.cursor_col)
                begin
                    $error("cursor_col: expected %0d, got %0d",
                           exp_w.cursor_col, out_word.cursor_col);
                    fail_count++;
                end
                if (out_word.cursor_row !== exp_w.cursor_row)
                begin
                    $error("cursor_row: expected %0d, got %0d",
                           exp_w.cursor_row, out_word.cursor_row);
                    fail_count++;
                end
                if (out_word.scrolled !== exp_w.scrolled)
                begin
                    $error("scrolled: expected %0d, got %0d",
                           exp_w.scrolled, out_word.scrolled);
                    fail_count++;
                end
                if (out_word.cell_data !== exp_w.cell_data)
                begin
                    $error("cell_data: expected %h, got %h",
                           exp_w.cell_data, out_word.cell_data);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stalls
    initial
    begin
        int burst;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 12);
                out_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        color_we = 1'b0;
        color_wdata = '0;
        color_model = RESET_COLOR;
        col_pos = 0;
        row_pos = 0;
        for (i = 0; i < CELLS; i++)
        begin
            screen_model[12'(i)] = {RESET_COLOR, CH_SPACE};
        end
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_char_codes();
        test_color();
        test_wrap_and_scroll();
        test_random();

        in_valid <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/tccw_pkg.sv
sv/text_console_char_writer.sv
test/text_console_char_writer_tb.sv
